@@ sv/bca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants of the batch counter with alarm.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT = 8;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DETECT_LOCKOUT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELAY_PULSE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUZZER_PULSE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUTTON_LOCKOUT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLL_PERIOD    = 3'd5;

    localparam logic [7:0]  COUNT_LIMIT_RESET    = 8'd10;
    localparam logic [15:0] DETECT_LOCKOUT_RESET = 16'd1000;
    localparam logic [15:0] RELAY_PULSE_RESET    = 16'd5000;
    localparam logic [15:0] BUZZER_PULSE_RESET   = 16'd500;
    localparam logic [15:0] BUTTON_LOCKOUT_RESET = 16'd200;
    localparam logic [15:0] POLL_PERIOD_RESET    = 16'd100;

    localparam int BIT_GREEN = 0;
    localparam int BIT_RED   = 1;
    localparam int BIT_RELAY = 2;
    localparam int BIT_BUZZ  = 3;

    typedef struct packed {
        logic [7:0]  count_limit;
        logic [15:0] detect_lockout_ticks;
        logic [15:0] relay_pulse_ticks;
        logic [15:0] buzzer_pulse_ticks;
        logic [15:0] button_lockout_ticks;
        logic [15:0] poll_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic sensor_level;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic       green_led;
        logic       red_led;
        logic       relay_drive;
        logic       buzzer_drive;
        logic [7:0] object_count;
    } out_item_t;

endpackage
`default_nettype wire

@@ sv/batch_counter_with_alarm_top.sv @@
`default_nettype none
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one tick per cycle unless the receiver stalls; the result register
// frees as it is taken, so input and output transfers overlap with no bubble.
// Reset: asynchronous, active low; counters, flags and out_valid clear, out_data
// does not; configuration returns to its defaults. There is no clearing pass.
// ----------------------------------------------------------------------------
// batch_counter_with_alarm_top
// Batch counter with alarm: one tick per transfer, counting detections up to
// a limit with relay pulse, button reset and buzzer alarm.
// ----------------------------------------------------------------------------
module batch_counter_with_alarm_top
    import bca_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_item_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output out_item_t                      out_data,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]               cfg_wdata
);

    cfg_t      cfg;
    out_item_t step_result;
    logic      in_xfer;

    logic [COUNT_BITS-1:0] cnt_reg,       cnt_next;
    logic [TIMER_BITS-1:0] since_det_reg, since_det_next;
    logic [TIMER_BITS-1:0] since_btn_reg, since_btn_next;
    logic [TIMER_BITS-1:0] since_buz_reg, since_buz_next;
    logic [TIMER_BITS-1:0] relay_rem_reg, relay_rem_next;
    logic [TIMER_BITS-1:0] poll_cd_reg,   poll_cd_next;
    logic                  held_reg,      held_next;
    logic                  buz_run_reg,   buz_run_next;
    logic [3:0]            bits_reg,      bits_next;

    assign in_xfer = in_valid && in_ready;

    bca_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bca_step #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cfg           (cfg),
        .sensor        (in_data.sensor_level),
        .button        (in_data.button_level),
        .cnt_cur       (cnt_reg),
        .since_det_cur (since_det_reg),
        .since_btn_cur (since_btn_reg),
        .since_buz_cur (since_buz_reg),
        .relay_rem_cur (relay_rem_reg),
        .poll_cd_cur   (poll_cd_reg),
        .held_cur      (held_reg),
        .buz_run_cur   (buz_run_reg),
        .bits_cur      (bits_reg),
        .cnt_nxt       (cnt_next),
        .since_det_nxt (since_det_next),
        .since_btn_nxt (since_btn_next),
        .since_buz_nxt (since_buz_next),
        .relay_rem_nxt (relay_rem_next),
        .poll_cd_nxt   (poll_cd_next),
        .held_nxt      (held_next),
        .buz_run_nxt   (buz_run_next),
        .bits_nxt      (bits_next),
        .result        (step_result)
    );

    bca_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer),
        .load_data (step_result),
        .slot_free (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            since_det_reg <= '0;
            since_btn_reg <= '0;
            since_buz_reg <= '0;
            relay_rem_reg <= '0;
            poll_cd_reg   <= '0;
            held_reg      <= 1'b0;
            buz_run_reg   <= 1'b0;
            bits_reg      <= 4'b0000;
        end
        else if (in_xfer)
        begin
            cnt_reg       <= cnt_next;
            since_det_reg <= since_det_next;
            since_btn_reg <= since_btn_next;
            since_buz_reg <= since_buz_next;
            relay_rem_reg <= relay_rem_next;
            poll_cd_reg   <= poll_cd_next;
            held_reg      <= held_next;
            buz_run_reg   <= buz_run_next;
            bits_reg      <= bits_next;
        end
    end

    // The relay drive is on exactly while a pulse is counting down.
    a_relay_matches_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg[BIT_RELAY] == (relay_rem_reg != '0))
        else $error("relay drive does not match pulse countdown");

    // No poll countdown runs during a relay pulse.
    a_no_poll_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (relay_rem_reg != '0) |-> (poll_cd_reg == '0))
        else $error("poll countdown active during relay pulse");

    // The count never changes while a pulse is running.
    a_count_frozen_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (relay_rem_reg != '0) |=> $stable(cnt_reg))
        else $error("count changed during relay pulse");

    // Green and red are never lit together.
    a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(bits_reg[BIT_GREEN] && bits_reg[BIT_RED]))
        else $error("green and red lit together");

    // A sounding buzzer always has its run flag set.
    a_buzzer_flag: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg[BIT_BUZZ] |-> buz_run_reg)
        else $error("buzzer sounding without run flag");

endmodule
`default_nettype wire

@@ sv/bca_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bca_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bca_cfg
    import bca_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]               cfg_wdata,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COUNT_LIMIT:    cfg_next.count_limit          = cfg_wdata[7:0];
                CFG_DETECT_LOCKOUT: cfg_next.detect_lockout_ticks = cfg_wdata;
                CFG_RELAY_PULSE:    cfg_next.relay_pulse_ticks    = cfg_wdata;
                CFG_BUZZER_PULSE:   cfg_next.buzzer_pulse_ticks   = cfg_wdata;
                CFG_BUTTON_LOCKOUT: cfg_next.button_lockout_ticks = cfg_wdata;
                CFG_POLL_PERIOD:    cfg_next.poll_period_ticks    = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_limit          <= COUNT_LIMIT_RESET;
            cfg_reg.detect_lockout_ticks <= DETECT_LOCKOUT_RESET;
            cfg_reg.relay_pulse_ticks    <= RELAY_PULSE_RESET;
            cfg_reg.buzzer_pulse_ticks   <= BUZZER_PULSE_RESET;
            cfg_reg.button_lockout_ticks <= BUTTON_LOCKOUT_RESET;
            cfg_reg.poll_period_ticks    <= POLL_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ sv/bca_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bca_step
// Next-state logic for one tick: pulse countdown, poll countdown or poll step.
// ----------------------------------------------------------------------------
module bca_step
    import bca_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire cfg_t                    cfg,
    input  wire logic                    sensor,
    input  wire logic                    button,
    input  wire logic [COUNT_BITS-1:0]   cnt_cur,
    input  wire logic [TIMER_BITS-1:0]   since_det_cur,
    input  wire logic [TIMER_BITS-1:0]   since_btn_cur,
    input  wire logic [TIMER_BITS-1:0]   since_buz_cur,
    input  wire logic [TIMER_BITS-1:0]   relay_rem_cur,
    input  wire logic [TIMER_BITS-1:0]   poll_cd_cur,
    input  wire logic                    held_cur,
    input  wire logic                    buz_run_cur,
    input  wire logic [3:0]              bits_cur,
    output logic      [COUNT_BITS-1:0]   cnt_nxt,
    output logic      [TIMER_BITS-1:0]   since_det_nxt,
    output logic      [TIMER_BITS-1:0]   since_btn_nxt,
    output logic      [TIMER_BITS-1:0]   since_buz_nxt,
    output logic      [TIMER_BITS-1:0]   relay_rem_nxt,
    output logic      [TIMER_BITS-1:0]   poll_cd_nxt,
    output logic                         held_nxt,
    output logic                         buz_run_nxt,
    output logic      [3:0]              bits_nxt,
    output out_item_t                    result
);

    localparam int TW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TW-1:0]         TIMER_MAX_EXT = TW'(TIMER_MAX);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [TW-1:0]         relay_ext;
    logic [TIMER_BITS-1:0] relay_load;
    logic [15:0]           poll_adj;
    logic [TW-1:0]         poll_ext;
    logic [TIMER_BITS-1:0] poll_load;

    always_comb
    begin
        relay_ext  = TW'(cfg.relay_pulse_ticks);
        relay_load = (relay_ext > TIMER_MAX_EXT) ? TIMER_MAX : relay_ext[TIMER_BITS-1:0];
        poll_adj   = (cfg.poll_period_ticks == 16'd0) ? 16'd0 : cfg.poll_period_ticks - 16'd1;
        poll_ext   = TW'(poll_adj);
        poll_load  = (poll_ext > TIMER_MAX_EXT) ? TIMER_MAX : poll_ext[TIMER_BITS-1:0];
    end

    logic eoc;
    logic det;

    always_comb
    begin
        cnt_nxt       = cnt_cur;
        since_det_nxt = since_det_cur;
        since_btn_nxt = since_btn_cur;
        since_buz_nxt = since_buz_cur;
        relay_rem_nxt = relay_rem_cur;
        poll_cd_nxt   = poll_cd_cur;
        held_nxt      = held_cur;
        buz_run_nxt   = buz_run_cur;
        bits_nxt      = bits_cur;
        eoc           = 1'b0;
        det           = 1'b0;

        if (relay_rem_cur != '0)
        begin
            relay_rem_nxt = relay_rem_cur - TIMER_ONE;
            if (relay_rem_nxt == '0)
            begin
                bits_nxt[BIT_RELAY] = 1'b0;
                eoc = 1'b1;
            end
        end
        else if (poll_cd_cur != '0)
        begin
            poll_cd_nxt = poll_cd_cur - TIMER_ONE;
        end
        else
        begin
            if (button && !held_cur && (TW'(since_btn_cur) >= TW'(cfg.button_lockout_ticks)))
            begin
                cnt_nxt       = '0;
                bits_nxt      = 4'b0000;
                since_btn_nxt = '0;
                held_nxt      = 1'b1;
            end
            else if (!button)
            begin
                held_nxt = 1'b0;
            end

            det = sensor && (TW'(since_det_cur) >= TW'(cfg.detect_lockout_ticks));
            if (det)
            begin
                if (CW'(cnt_nxt) < CW'(cfg.count_limit))
                begin
                    if (cnt_nxt < COUNT_MAX)
                    begin
                        cnt_nxt = cnt_nxt + COUNT_ONE;
                    end
                    since_det_nxt = '0;
                end
                if (CW'(cnt_nxt) < CW'(cfg.count_limit))
                begin
                    bits_nxt[BIT_GREEN] = 1'b1;
                    bits_nxt[BIT_RELAY] = 1'b1;
                    bits_nxt[BIT_RED]   = 1'b0;
                    relay_rem_nxt = relay_load;
                    if (relay_load == '0)
                    begin
                        bits_nxt[BIT_RELAY] = 1'b0;
                        eoc = 1'b1;
                    end
                end
                else
                begin
                    eoc = 1'b1;
                end
            end
            else if (CW'(cnt_nxt) >= CW'(cfg.count_limit))
            begin
                bits_nxt[BIT_RED]   = 1'b1;
                bits_nxt[BIT_GREEN] = 1'b0;
                bits_nxt[BIT_RELAY] = 1'b0;
                if (!buz_run_nxt)
                begin
                    since_buz_nxt      = '0;
                    bits_nxt[BIT_BUZZ] = 1'b1;
                    buz_run_nxt        = 1'b1;
                end
                eoc = 1'b1;
            end
            else
            begin
                bits_nxt[BIT_GREEN] = 1'b1;
                bits_nxt[BIT_RED]   = 1'b0;
                bits_nxt[BIT_RELAY] = 1'b0;
                bits_nxt[BIT_BUZZ]  = 1'b0;
                buz_run_nxt         = 1'b0;
                eoc = 1'b1;
            end
        end

        if (eoc)
        begin
            if (buz_run_nxt && (TW'(since_buz_nxt) >= TW'(cfg.buzzer_pulse_ticks)))
            begin
                bits_nxt[BIT_BUZZ] = 1'b0;
                buz_run_nxt        = 1'b0;
            end
            poll_cd_nxt = poll_load;
        end

        result.green_led    = bits_nxt[BIT_GREEN];
        result.red_led      = bits_nxt[BIT_RED];
        result.relay_drive  = bits_nxt[BIT_RELAY];
        result.buzzer_drive = bits_nxt[BIT_BUZZ];
        result.object_count = 8'(CW'(cnt_nxt));

        if (since_det_nxt != TIMER_MAX)
        begin
            since_det_nxt = since_det_nxt + TIMER_ONE;
        end
        if (since_btn_nxt != TIMER_MAX)
        begin
            since_btn_nxt = since_btn_nxt + TIMER_ONE;
        end
        if (since_buz_nxt != TIMER_MAX)
        begin
            since_buz_nxt = since_buz_nxt + TIMER_ONE;
        end
    end

endmodule
`default_nettype wire

@@ sv/bca_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bca_out_stage
// Result register with valid and ready; loads a new result on every input
// transfer and frees the slot when the result transfer completes.
// ----------------------------------------------------------------------------
module bca_out_stage
    import bca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t load_data,
    output logic           slot_free,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

@@ tb/sv/batch_counter_with_alarm_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// batch_counter_with_alarm_top_test
// Self-checking test of the batch counter with alarm. A queue of ticks feeds
// a valid/ready driver, and every accepted tick runs through an in-house
// model of the counter, relay, button and buzzer timing. The monitor compares
// each output transfer field by field with the oldest predicted result. The
// run walks through the reset settings, a directed sequence, boundary
// settings and random settings, with random idling on both sides, one long
// receiver stall and sender pauses until the block drains.
// ----------------------------------------------------------------------------
module batch_counter_with_alarm_top_test
    import bca_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT = 10;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 80;
    localparam logic [43:0] DIRECTED_TICKS = {
        2'b00, 2'b10, 2'b10, 2'b10, 2'b00, 2'b01, 2'b01, 2'b11, 2'b00, 2'b11, 2'b11,
        2'b00, 2'b10, 2'b10, 2'b00, 2'b00, 2'b11, 2'b01, 2'b00, 2'b10, 2'b10, 2'b00
    };

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    in_item_t                  in_data = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [15:0]               cfg_wdata = '0;

    in_item_t  pending_ticks[$];
    out_item_t expected_outputs[$];
    logic      in_taken = 1'b0;
    bit        calm = 1'b0;
    int        mismatch_count = 0;
    int        outputs_seen = 0;
    int        idle_cycles = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    cfg_t        cfg_shadow;
    logic [7:0]  count_val;
    logic [15:0] since_detect;
    logic [15:0] since_button;
    logic [15:0] since_buzzer;
    logic [15:0] relay_left;
    logic [15:0] poll_left;
    logic        button_held;
    logic        buzzer_armed;
    logic [3:0]  lamp_bits;

    batch_counter_with_alarm_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] step_timer(input logic [15:0] value);
        return (value == 16'hFFFF) ? value : value + 16'd1;
    endfunction

    function void model_reset();
        cfg_shadow = cfg_t'{COUNT_LIMIT_RESET, DETECT_LOCKOUT_RESET, RELAY_PULSE_RESET,
                            BUZZER_PULSE_RESET, BUTTON_LOCKOUT_RESET, POLL_PERIOD_RESET};
        count_val = '0;
        since_detect = '0;
        since_button = '0;
        since_buzzer = '0;
        relay_left = '0;
        poll_left = '0;
        button_held = 1'b0;
        buzzer_armed = 1'b0;
        lamp_bits = '0;
    endfunction

    function void close_poll();
        if (buzzer_armed && since_buzzer >= cfg_shadow.buzzer_pulse_ticks)
        begin
            lamp_bits[BIT_BUZZ] = 1'b0;
            buzzer_armed = 1'b0;
        end
        poll_left = (cfg_shadow.poll_period_ticks == 16'd0) ? 16'd0
                                                           : cfg_shadow.poll_period_ticks - 16'd1;
    endfunction

    function void poll_inputs(input logic sensor, input logic button);
        logic pulse_started;
        pulse_started = 1'b0;
        if (button && !button_held && since_button >= cfg_shadow.button_lockout_ticks)
        begin
            count_val = '0;
            lamp_bits = '0;
            since_button = '0;
            button_held = 1'b1;
        end
        else if (!button)
        begin
            button_held = 1'b0;
        end

        if (sensor && since_detect >= cfg_shadow.detect_lockout_ticks)
        begin
            if (count_val < cfg_shadow.count_limit)
            begin
                if (count_val != 8'hFF)
                begin
                    count_val = count_val + 8'd1;
                end
                since_detect = '0;
            end
            if (count_val < cfg_shadow.count_limit)
            begin
                lamp_bits[BIT_GREEN] = 1'b1;
                lamp_bits[BIT_RELAY] = 1'b1;
                lamp_bits[BIT_RED] = 1'b0;
                relay_left = cfg_shadow.relay_pulse_ticks;
                pulse_started = (relay_left != 16'd0);
                if (!pulse_started)
                begin
                    lamp_bits[BIT_RELAY] = 1'b0;
                end
            end
        end
        else if (count_val >= cfg_shadow.count_limit)
        begin
            lamp_bits[BIT_RED] = 1'b1;
            lamp_bits[BIT_GREEN] = 1'b0;
            lamp_bits[BIT_RELAY] = 1'b0;
            if (!buzzer_armed)
            begin
                since_buzzer = '0;
                lamp_bits[BIT_BUZZ] = 1'b1;
                buzzer_armed = 1'b1;
            end
        end
        else
        begin
            lamp_bits[BIT_GREEN] = 1'b1;
            lamp_bits[BIT_RED] = 1'b0;
            lamp_bits[BIT_RELAY] = 1'b0;
            lamp_bits[BIT_BUZZ] = 1'b0;
            buzzer_armed = 1'b0;
        end

        if (!pulse_started)
        begin
            close_poll();
        end
    endfunction

    function out_item_t predict_outputs(input in_item_t tick);
        out_item_t result;
        if (relay_left != 16'd0)
        begin
            relay_left = relay_left - 16'd1;
            if (relay_left == 16'd0)
            begin
                lamp_bits[BIT_RELAY] = 1'b0;
                close_poll();
            end
        end
        else if (poll_left != 16'd0)
        begin
            poll_left = poll_left - 16'd1;
        end
        else
        begin
            poll_inputs(tick.sensor_level, tick.button_level);
        end

        result.green_led = lamp_bits[BIT_GREEN];
        result.red_led = lamp_bits[BIT_RED];
        result.relay_drive = lamp_bits[BIT_RELAY];
        result.buzzer_drive = lamp_bits[BIT_BUZZ];
        result.object_count = count_val;

        since_detect = step_timer(since_detect);
        since_button = step_timer(since_button);
        since_buzzer = step_timer(since_buzzer);
        return result;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
    endtask

    task automatic load_settings(input cfg_t settings);
        write_reg(CFG_COUNT_LIMIT, {8'd0, settings.count_limit});
        write_reg(CFG_DETECT_LOCKOUT, settings.detect_lockout_ticks);
        write_reg(CFG_RELAY_PULSE, settings.relay_pulse_ticks);
        write_reg(CFG_BUZZER_PULSE, settings.buzzer_pulse_ticks);
        write_reg(CFG_BUTTON_LOCKOUT, settings.button_lockout_ticks);
        write_reg(CFG_POLL_PERIOD, settings.poll_period_ticks);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_shadow = settings;
    endtask

    task automatic push_random(input int count, input int sense_pct, input int press_pct);
        in_item_t tick;
        repeat (count)
        begin
            tick.sensor_level = ($urandom_range(99) < sense_pct);
            tick.button_level = ($urandom_range(99) < press_pct);
            pending_ticks.push_back(tick);
        end
    endtask

    task automatic push_fixed(input int count, input in_item_t tick);
        repeat (count)
        begin
            pending_ticks.push_back(tick);
        end
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || in_valid || expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expected_outputs.push_back(predict_outputs(in_data));
        end
    end

    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (rst_n && pending_ticks.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_data <= pending_ticks.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && outputs_seen >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            outputs_seen <= outputs_seen + 1;
            if (expected_outputs.size() == 0)
            begin
                report_error("output transfer with no prediction pending");
            end
            else
            begin
                want = expected_outputs.pop_front();
                compare_field("green_led", 8'(out_data.green_led), 8'(want.green_led));
                compare_field("red_led", 8'(out_data.red_led), 8'(want.red_led));
                compare_field("relay_drive", 8'(out_data.relay_drive), 8'(want.relay_drive));
                compare_field("buzzer_drive", 8'(out_data.buzzer_drive),
                              8'(want.buzzer_drive));
                compare_field("object_count", out_data.object_count, want.object_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t settings;
        int   k;
        model_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_random(120, 50, 10);
        wait_idle();

        load_settings(cfg_t'{8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        for (k = 0; k < 22; k++)
        begin
            pending_ticks.push_back(in_item_t'(DIRECTED_TICKS[43 - 2 * k -: 2]));
        end
        wait_idle();

        load_settings(cfg_t'{8'd3, 16'd2, 16'd3, 16'd4, 16'd3, 16'd1});
        push_random(250, 60, 8);
        wait_idle();

        load_settings(cfg_t'{8'd0, 16'd0, 16'd1, 16'd2, 16'd0, 16'd2});
        push_random(100, 50, 20);
        wait_idle();

        load_settings(cfg_t'{8'd255, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1});
        push_random(300, 95, 1);
        wait_idle();

        for (k = 0; k < 4; k++)
        begin
            settings.count_limit = 8'($urandom_range(6, 1));
            settings.detect_lockout_ticks = 16'($urandom_range(6));
            settings.relay_pulse_ticks = 16'($urandom_range(8));
            settings.buzzer_pulse_ticks = 16'($urandom_range(10));
            settings.button_lockout_ticks = 16'($urandom_range(6));
            settings.poll_period_ticks = 16'($urandom_range(4));
            load_settings(settings);
            if (k == 0)
            begin
                push_random(60, 55, 6);
                wait_idle();
                push_random(60, 55, 6);
            end
            else
            begin
                calm = (k == 2);
                push_random(120, 55, 6);
            end
            wait_idle();
            calm = 1'b0;
        end

        load_settings(cfg_t'{8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF});
        push_fixed(12, in_item_t'(2'b10));
        push_random(30, 50, 20);
        wait_idle();

        repeat (4) @(posedge clk);
        if (expected_outputs.size() != 0)
        begin
            report_error("predicted results left without an output transfer");
        end
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bca_pkg.sv
sv/bca_cfg.sv
sv/bca_step.sv
sv/bca_out_stage.sv
sv/batch_counter_with_alarm_top.sv
tb/sv/batch_counter_with_alarm_top_test.sv
